// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: hw/rtl/ufp_pkg.sv
// ----------------------------------------------------------------------------
// ufp_pkg
// shared types and constants of the urlencoded pair parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ufp_pkg;

    localparam int P_PAIR_MAX = 64;

    localparam int BYTE_W     = 8;
    localparam int NUM_W      = 8;
    localparam int ARENA_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [NUM_W-1:0]   RST_PAIR_LIMIT = 8'd64;
    localparam logic [ARENA_W-1:0] RST_ARENA_CAP  = 16'd4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_CAP  = 2'd1;

    // characters
    localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;
    localparam logic [BYTE_W-1:0] CH_EQ   = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_PCT  = 8'h25;
    localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIN,
        ST_CNT_K,
        ST_CNT_K_W,
        ST_CHK_K,
        ST_CNT_V,
        ST_CNT_V_W,
        ST_CHK_V,
        ST_COMMIT,
        ST_EMIT_K,
        ST_EMIT_K_W,
        ST_EMIT_V,
        ST_EMIT_V_W,
        ST_MARK,
        ST_TALLY,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_A,
        SC_B,
        SC_C,
        SC_D,
        SC_OUT,
        SC_FIN
    } t_scan_state;

    typedef struct packed {
        logic start;
        logic take;
    } t_scan_ctl;

    typedef struct packed {
        logic valid;
        logic last;
        logic done;
    } t_scan_sts;

endpackage

// File: hw/rtl/ufp_mem.sv
// ----------------------------------------------------------------------------
// ufp_mem
// pair buffer: one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ufp_mem #(
    parameter int PAIR_MAX = ufp_pkg::P_PAIR_MAX
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(PAIR_MAX)-1:0]      i_waddr,
    input  logic [ufp_pkg::BYTE_W-1:0]       i_wdata,
    input  logic [$clog2(PAIR_MAX)-1:0]      i_raddr,
    output logic [ufp_pkg::BYTE_W-1:0]       o_rdata
);
    import ufp_pkg::*;

    logic [BYTE_W-1:0] r_mem [PAIR_MAX];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ufp_scan.sv
// ----------------------------------------------------------------------------
// ufp_scan
// percent decoder that walks one side of the buffered pair, one decoded byte per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ufp_scan #(
    parameter int PAIR_MAX = ufp_pkg::P_PAIR_MAX
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ufp_pkg::t_scan_ctl                    i_ctl,
    input  logic [$clog2(PAIR_MAX+4)-1:0]         i_lo,
    input  logic [$clog2(PAIR_MAX+4)-1:0]         i_hi,
    input  logic [ufp_pkg::BYTE_W-1:0]            i_rd_data,
    output logic [$clog2(PAIR_MAX)-1:0]           o_rd_addr,
    output ufp_pkg::t_scan_sts                    o_sts,
    output logic [ufp_pkg::BYTE_W-1:0]            o_data,
    output logic [$clog2(PAIR_MAX+4)-1:0]         o_count
);
    import ufp_pkg::*;

    localparam int LW = $clog2(PAIR_MAX + 4);
    localparam int AW = $clog2(PAIR_MAX);

    t_scan_state       r_state, n_state;
    logic [LW-1:0]     r_pos, n_pos;
    logic [LW-1:0]     r_hi, n_hi;
    logic [LW-1:0]     r_cnt, n_cnt;
    logic [3:0]        r_hnib, n_hnib;
    logic              r_hok, n_hok;
    logic [BYTE_W-1:0] r_res, n_res;
    logic [1:0]        r_step, n_step;

    logic [LW-1:0]     pos_p1;
    logic [LW-1:0]     pos_p2;
    logic [LW-1:0]     pos_nx;
    logic              has_two;
    logic              side_end;
    logic [4:0]        hex_rd;

    // {ok, nibble}
    function automatic logic [4:0] hex_nib(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] lc;
        logic [4:0]        res;
        lc  = c | 8'h20;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, c[3:0]};
        end else if (lc >= 8'h61 && lc <= 8'h66) begin
            res = {1'b1, 4'(lc - 8'h57)};
        end
        return res;
    endfunction

    assign pos_p1   = r_pos + LW'(1);
    assign pos_p2   = r_pos + LW'(2);
    assign pos_nx   = r_pos + LW'(r_step);
    assign has_two  = pos_p2 < r_hi;
    assign side_end = pos_nx >= r_hi;
    assign hex_rd   = hex_nib(i_rd_data);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SC_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (i_lo >= i_hi) ? SC_FIN : SC_A;
                end
            end
            SC_A: n_state = SC_B;
            SC_B: begin
                if (i_rd_data == CH_PCT && has_two) begin
                    n_state = SC_C;
                end else begin
                    n_state = SC_OUT;
                end
            end
            SC_C: n_state = SC_D;
            SC_D: n_state = SC_OUT;
            SC_OUT: begin
                if (i_ctl.take) begin
                    n_state = side_end ? SC_FIN : SC_A;
                end
            end
            SC_FIN: n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rd_addr  = r_pos[AW-1:0];
        o_sts      = '0;
        unique case (r_state)
            SC_B:    o_rd_addr = pos_p1[AW-1:0];
            SC_C:    o_rd_addr = pos_p2[AW-1:0];
            SC_OUT: begin
                o_sts.valid = 1'b1;
                o_sts.last  = side_end;
            end
            SC_FIN:  o_sts.done = 1'b1;
            default: o_rd_addr = r_pos[AW-1:0];
        endcase
    end

    assign o_data  = r_res;
    assign o_count = r_cnt;

    // datapath
    always_comb begin
        n_pos  = r_pos;
        n_hi   = r_hi;
        n_cnt  = r_cnt;
        n_hnib = r_hnib;
        n_hok  = r_hok;
        n_res  = r_res;
        n_step = r_step;
        case (r_state)
            SC_IDLE: begin
                if (i_ctl.start) begin
                    n_pos = i_lo;
                    n_hi  = i_hi;
                    n_cnt = '0;
                end
            end
            SC_B: begin
                n_step = 2'd1;
                n_res  = (i_rd_data == CH_PLUS) ? CH_SP : i_rd_data;
            end
            SC_C: begin
                n_hnib = hex_rd[3:0];
                n_hok  = hex_rd[4];
            end
            SC_D: begin
                if (r_hok && hex_rd[4]) begin
                    n_res  = {r_hnib, hex_rd[3:0]};
                    n_step = 2'd3;
                end else begin
                    n_res  = CH_PCT;
                    n_step = 2'd1;
                end
            end
            SC_OUT: begin
                if (i_ctl.take) begin
                    n_pos = pos_nx;
                    n_cnt = r_cnt + LW'(1);
                end
            end
            default: n_pos = r_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_hi   <= n_hi;
        r_cnt  <= n_cnt;
        r_hnib <= n_hnib;
        r_hok  <= n_hok;
        r_res  <= n_res;
        r_step <= n_step;
    end

endmodule

// File: hw/rtl/form_urlencoded_pair_parser.sv
// ----------------------------------------------------------------------------
// form_urlencoded_pair_parser
// splits a query text into key/value pairs and emits percent-decoded bytes
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+--------------------------------
//  in       | input     | i_in_valid / o_in_stall      | i_text_byte, i_last_byte
//  out      | output    | o_out_valid / i_out_stall    | o_data_byte, o_byte_valid,
//           |           |                              | o_in_value, o_pair_end,
//           |           |                              | o_pair_number, o_status
//  cfg      | input     | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
//  a text byte that does not end a pair is accepted without stalling the input
//  a byte that ends a pair ('&' or last) stalls the input while the pair is walked
//  a side with '%' or '+' gets a sizing walk first, each nonempty side an emit walk
//  a walk reads each byte, and the two bytes behind a '%', through the one read port
//  reset is synchronous active low; the pair buffer needs no clearing pass
//  an output beat waits in a register; a stall there holds the decoder at its current byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module form_urlencoded_pair_parser #(
    parameter int PAIR_MAX = ufp_pkg::P_PAIR_MAX
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  logic [ufp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ufp_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ufp_pkg::BYTE_W-1:0]        i_text_byte,
    input  logic                              i_last_byte,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ufp_pkg::BYTE_W-1:0]        o_data_byte,
    output logic                              o_byte_valid,
    output logic                              o_in_value,
    output logic                              o_pair_end,
    output logic [ufp_pkg::NUM_W-1:0]         o_pair_number,
    output logic                              o_status
);
    import ufp_pkg::*;

    localparam int LW = $clog2(PAIR_MAX + 4);
    localparam int AW = $clog2(PAIR_MAX);

    t_state             r_state, n_state;

    logic [NUM_W-1:0]   r_pair_limit;
    logic [ARENA_W-1:0] r_arena_cap;

    logic [LW-1:0]      r_len, n_len;
    logic               r_eq_seen, n_eq_seen;
    logic [LW-1:0]      r_eq_pos, n_eq_pos;
    logic               r_key_nd, n_key_nd;
    logic               r_val_nd, n_val_nd;
    logic               r_ovf, n_ovf;
    logic [ARENA_W-1:0] r_arena, n_arena;
    logic [NUM_W-1:0]   r_pairs, n_pairs;
    logic               r_limit, n_limit;
    logic               r_last, n_last;
    logic [ARENA_W-1:0] r_tmp, n_tmp;

    logic               r_o_valid, n_o_valid;
    logic [BYTE_W-1:0]  r_o_data, n_o_data;
    logic               r_o_bvalid, n_o_bvalid;
    logic               r_o_inval, n_o_inval;
    logic               r_o_end, n_o_end;
    logic [NUM_W-1:0]   r_o_num, n_o_num;
    logic               r_o_status, n_o_status;

    logic               in_acc;
    logic               lim;
    logic               buf_we;
    logic [LW-1:0]      k_len;
    logic [LW-1:0]      v_lo;
    logic [LW-1:0]      v_len;
    logic               k_over;
    logic               v_over;
    logic               slot_free;
    logic               side_val;
    logic               emit_load;
    logic               mark_load;
    logic               in_stall;
    logic [NUM_W-1:0]   pairs_inc;
    logic               scan_wait;

    t_scan_ctl          scan_ctl;
    t_scan_sts          scan_sts;
    logic [LW-1:0]      scan_lo;
    logic [LW-1:0]      scan_hi;
    logic [BYTE_W-1:0]  scan_data;
    logic [LW-1:0]      scan_cnt;
    logic [AW-1:0]      rd_addr;
    logic [BYTE_W-1:0]  rd_data;

    ufp_mem #(
        .PAIR_MAX (PAIR_MAX)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_text_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    ufp_scan #(
        .PAIR_MAX (PAIR_MAX)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_lo      (scan_lo),
        .i_hi      (scan_hi),
        .i_rd_data (rd_data),
        .o_rd_addr (rd_addr),
        .o_sts     (scan_sts),
        .o_data    (scan_data),
        .o_count   (scan_cnt)
    );

    assign in_acc    = i_in_valid && !in_stall;
    assign lim       = r_limit || (r_pairs >= r_pair_limit);
    assign buf_we    = in_acc && !lim && (i_text_byte != CH_AMP) && (r_len < LW'(PAIR_MAX));
    assign k_len     = r_eq_seen ? r_eq_pos : r_len;
    assign v_lo      = r_eq_seen ? (r_eq_pos + LW'(1)) : r_len;
    assign v_len     = r_len - v_lo;
    assign k_over    = ({1'b0, r_tmp} + (ARENA_W+1)'(k_len)) > {1'b0, r_arena_cap};
    assign v_over    = ({1'b0, r_tmp} + (ARENA_W+1)'(v_len)) > {1'b0, r_arena_cap};
    assign slot_free = !r_o_valid || !i_out_stall;
    assign scan_lo   = side_val ? v_lo : '0;
    assign scan_hi   = side_val ? r_len : k_len;
    assign pairs_inc = r_pairs + NUM_W'(1);
    assign scan_wait = (r_state == ST_CNT_K_W) || (r_state == ST_CNT_V_W) ||
                       (r_state == ST_EMIT_K_W) || (r_state == ST_EMIT_V_W);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && !lim && (i_text_byte == CH_AMP || i_last_byte)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_ovf) begin
                    n_state = ST_MARK;
                end else if (r_len == '0) begin
                    n_state = ST_DONE;
                end else if (r_key_nd) begin
                    n_state = ST_CNT_K;
                end else if (r_val_nd) begin
                    n_state = ST_CNT_V;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_CNT_K: n_state = ST_CNT_K_W;
            ST_CNT_K_W: begin
                if (scan_sts.done) begin
                    n_state = ST_CHK_K;
                end
            end
            ST_CHK_K: begin
                if (k_over) begin
                    n_state = ST_DONE;
                end else if (r_val_nd) begin
                    n_state = ST_CNT_V;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_CNT_V: n_state = ST_CNT_V_W;
            ST_CNT_V_W: begin
                if (scan_sts.done) begin
                    n_state = ST_CHK_V;
                end
            end
            ST_CHK_V: n_state = v_over ? ST_DONE : ST_COMMIT;
            ST_COMMIT: begin
                if (k_len == '0 && v_len == '0) begin
                    n_state = ST_MARK;
                end else if (k_len != '0) begin
                    n_state = ST_EMIT_K;
                end else begin
                    n_state = ST_EMIT_V;
                end
            end
            ST_EMIT_K: n_state = ST_EMIT_K_W;
            ST_EMIT_K_W: begin
                if (scan_sts.done) begin
                    n_state = (v_len != '0) ? ST_EMIT_V : ST_TALLY;
                end
            end
            ST_EMIT_V: n_state = ST_EMIT_V_W;
            ST_EMIT_V_W: begin
                if (scan_sts.done) begin
                    n_state = ST_TALLY;
                end
            end
            ST_MARK: begin
                if (slot_free) begin
                    n_state = r_ovf ? ST_DONE : ST_TALLY;
                end
            end
            ST_TALLY: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_stall       = 1'b1;
        scan_ctl.start = 1'b0;
        scan_ctl.take  = 1'b0;
        side_val       = 1'b0;
        emit_load      = 1'b0;
        mark_load      = 1'b0;
        unique case (r_state) inside
            ST_IDLE:  in_stall = 1'b0;
            ST_CNT_K, ST_EMIT_K: scan_ctl.start = 1'b1;
            ST_CNT_V, ST_EMIT_V: begin
                scan_ctl.start = 1'b1;
                side_val       = 1'b1;
            end
            ST_CNT_K_W: scan_ctl.take = 1'b1;
            ST_CNT_V_W: begin
                scan_ctl.take = 1'b1;
                side_val      = 1'b1;
            end
            ST_EMIT_K_W: begin
                scan_ctl.take = slot_free;
                emit_load     = scan_sts.valid && slot_free;
            end
            ST_EMIT_V_W: begin
                scan_ctl.take = slot_free;
                emit_load     = scan_sts.valid && slot_free;
                side_val      = 1'b1;
            end
            ST_MARK:  mark_load = slot_free;
            default:  in_stall = 1'b1;
        endcase
    end

    // pair and text bookkeeping
    always_comb begin
        n_len     = r_len;
        n_eq_seen = r_eq_seen;
        n_eq_pos  = r_eq_pos;
        n_key_nd  = r_key_nd;
        n_val_nd  = r_val_nd;
        n_ovf     = r_ovf;
        n_arena   = r_arena;
        n_pairs   = r_pairs;
        n_limit   = r_limit;
        n_last    = r_last;
        n_tmp     = r_tmp;
        case (r_state) inside
            ST_IDLE: begin
                if (in_acc) begin
                    n_last = i_last_byte;
                    if (lim) begin
                        n_limit = 1'b1;
                        if (i_last_byte) begin
                            n_len     = '0;
                            n_eq_seen = 1'b0;
                            n_key_nd  = 1'b0;
                            n_val_nd  = 1'b0;
                            n_ovf     = 1'b0;
                            n_arena   = '0;
                            n_pairs   = '0;
                            n_limit   = 1'b0;
                        end
                    end else if (i_text_byte != CH_AMP) begin
                        if (r_len >= LW'(PAIR_MAX)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_len = r_len + LW'(1);
                            if (i_text_byte == CH_EQ) begin
                                if (!r_eq_seen) begin
                                    n_eq_seen = 1'b1;
                                    n_eq_pos  = r_len;
                                end
                            end else if (i_text_byte == CH_PCT || i_text_byte == CH_PLUS) begin
                                if (r_eq_seen) begin
                                    n_val_nd = 1'b1;
                                end else begin
                                    n_key_nd = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            ST_FIN:   n_tmp = r_arena;
            ST_CHK_K, ST_CHK_V: n_tmp = r_tmp + ARENA_W'(scan_cnt);
            ST_COMMIT: n_arena = r_tmp;
            ST_TALLY: begin
                n_pairs = pairs_inc;
                if (pairs_inc >= r_pair_limit) begin
                    n_limit = 1'b1;
                end
            end
            ST_DONE: begin
                n_len     = '0;
                n_eq_seen = 1'b0;
                n_key_nd  = 1'b0;
                n_val_nd  = 1'b0;
                n_ovf     = 1'b0;
                if (r_last) begin
                    n_arena = '0;
                    n_pairs = '0;
                    n_limit = 1'b0;
                end
            end
            default: n_tmp = r_tmp;
        endcase
    end

    // output register
    always_comb begin
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_data   = r_o_data;
        n_o_bvalid = r_o_bvalid;
        n_o_inval  = r_o_inval;
        n_o_end    = r_o_end;
        n_o_num    = r_o_num;
        n_o_status = r_o_status;
        if (emit_load) begin
            n_o_valid  = 1'b1;
            n_o_data   = scan_data;
            n_o_bvalid = 1'b1;
            n_o_inval  = side_val;
            n_o_end    = scan_sts.last && (side_val || v_len == '0);
            n_o_num    = r_pairs;
            n_o_status = 1'b0;
        end else if (mark_load) begin
            n_o_valid  = 1'b1;
            n_o_data   = '0;
            n_o_bvalid = 1'b0;
            n_o_inval  = 1'b0;
            n_o_end    = 1'b1;
            n_o_num    = r_pairs;
            n_o_status = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pair_limit <= RST_PAIR_LIMIT;
            r_arena_cap  <= RST_ARENA_CAP;
            r_len        <= '0;
            r_eq_seen    <= 1'b0;
            r_key_nd     <= 1'b0;
            r_val_nd     <= 1'b0;
            r_ovf        <= 1'b0;
            r_arena      <= '0;
            r_pairs      <= '0;
            r_limit      <= 1'b0;
            r_last       <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_eq_seen <= n_eq_seen;
            r_key_nd  <= n_key_nd;
            r_val_nd  <= n_val_nd;
            r_ovf     <= n_ovf;
            r_arena   <= n_arena;
            r_pairs   <= n_pairs;
            r_limit   <= n_limit;
            r_last    <= n_last;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PAIR_LIMIT: r_pair_limit <= i_cfg_data[NUM_W-1:0];
                    CFG_ARENA_CAP:  r_arena_cap  <= i_cfg_data[ARENA_W-1:0];
                    default: r_pair_limit <= r_pair_limit;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eq_pos   <= n_eq_pos;
        r_tmp      <= n_tmp;
        r_o_data   <= n_o_data;
        r_o_bvalid <= n_o_bvalid;
        r_o_inval  <= n_o_inval;
        r_o_end    <= n_o_end;
        r_o_num    <= n_o_num;
        r_o_status <= n_o_status;
    end

    assign o_in_stall    = in_stall;
    assign o_out_valid   = r_o_valid;
    assign o_data_byte   = r_o_data;
    assign o_byte_valid  = r_o_bvalid;
    assign o_in_value    = r_o_inval;
    assign o_pair_end    = r_o_end;
    assign o_pair_number = r_o_num;
    assign o_status      = r_o_status;

    // a waiting beat is never overwritten
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, r_o_valid && i_out_stall, !(emit_load || mark_load))
    // buffered length stays within the buffer
    `ASSERT_IMPLY(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LW'(PAIR_MAX))
    // decoder offers a byte only while the sequencer is waiting on it
    `ASSERT_IMPLY(a_scan_owned, i_clk, i_rst_n, scan_sts.valid, scan_wait)
    // a tallied pair always finishes in the following cycle
    `ASSERT_NEXT(a_tally_done, i_clk, i_rst_n, r_state == ST_TALLY, r_state == ST_DONE && r_pairs == $past(pairs_inc))

endmodule
